[hdl/fcrc_pkg.sv]
// shared types, class codes and crc function for the framed crc-8 receiver
package fcrc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam int unsigned CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_SEQ  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_LEN  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_REG  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_DATA = 3'd3;
  localparam logic [CLS_W-1:0] CLS_CRC  = 3'd4;

  localparam logic RESULT_PAYLOAD = 1'b0;
  localparam logic RESULT_STATUS  = 1'b1;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [7:0]       data;
  } fcrc_item_t;

  typedef struct packed {
    logic [7:0] frame_seq;
    logic [7:0] expected_crc;
    logic       crc_ok;
    logic       is_register;
    logic [7:0] payload_byte;
  } fcrc_result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] x;
    logic       fb;
    c = crc;
    x = b;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ x[0];
      c = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      x = {1'b0, x[7:1]};
    end
    return c;
  endfunction

endpackage

[hdl/frame_receiver_crc8_check_top.sv]
// top level of the framed byte receiver with crc-8 check
//
// channel   direction  fields
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tuser result_kind; tdata payload, flags, crc, sequence
//
// one byte accepted per cycle when the queue has room; each byte is held
// in the queue, and its result is then registered in the result register
// sequence and length bytes flow through the queue but give no result
// a stalled output fills the queue, then s_tready drops
// rst is synchronous and returns the parser to the start of a frame
module frame_receiver_crc8_check_top #(
  parameter int unsigned QUEUE_DEPTH = fcrc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] payload_byte, [8] is_register, [9] crc_ok,
                                 // [17:10] expected_crc, [25:18] frame_seq, rest zero
  output logic        m_tuser    // [0] result_kind
);

  fcrc_pkg::fcrc_item_t   push_item;
  fcrc_pkg::fcrc_item_t   pop_item;
  fcrc_pkg::fcrc_result_t out_result;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  fcrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  fcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .count      (q_count)
  );

  fcrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_result (out_result)
  );

  assign m_tdata = {6'd0, out_result};

  a_status_no_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == fcrc_pkg::RESULT_STATUS) |-> m_tdata[8:0] == 9'd0)
    else $error("status transaction carries payload bits");

  a_payload_no_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == fcrc_pkg::RESULT_PAYLOAD) |-> m_tdata[17:9] == 9'd0)
    else $error("payload transaction carries crc bits");

  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> q_count != '0)
    else $error("accepted byte missing from queue");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

[hdl/fcrc_front.sv]
// front end: accepts received bytes and tags each with its place in the frame
module fcrc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  output logic                push_valid,
  input  logic                push_ready,
  output fcrc_pkg::fcrc_item_t push_item
);

  localparam logic [2:0] PH_SEQ  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_REG  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] remaining;
  logic [7:0] remaining_next;
  logic [fcrc_pkg::CLS_W-1:0] cls;
  logic       take;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;
  assign push_item.cls  = cls;
  assign push_item.data = in_byte;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    cls            = fcrc_pkg::CLS_SEQ;
    unique case (phase)
      PH_LEN: begin
        cls            = fcrc_pkg::CLS_LEN;
        remaining_next = in_byte;
        phase_next     = PH_REG;
      end
      PH_REG: begin
        cls        = fcrc_pkg::CLS_REG;
        phase_next = (remaining != 8'd0) ? PH_DATA : PH_CRC;
      end
      PH_DATA: begin
        cls            = fcrc_pkg::CLS_DATA;
        remaining_next = remaining - 8'd1;
        if (remaining == 8'd1) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        cls            = fcrc_pkg::CLS_CRC;
        remaining_next = 8'd0;
        phase_next     = PH_SEQ;
      end
      default: begin
        cls            = fcrc_pkg::CLS_SEQ;
        remaining_next = 8'd0;
        phase_next     = PH_LEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEQ;
      remaining <= 8'd0;
    end else if (take) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

endmodule

[hdl/fcrc_queue.sv]
// short queue of tagged bytes between front and back
module fcrc_queue #(
  parameter int unsigned DEPTH = fcrc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  fcrc_pkg::fcrc_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output fcrc_pkg::fcrc_item_t pop_item,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  fcrc_pkg::fcrc_item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hdl/fcrc_back.sv]
// back end: running crc, sequence latch and registered result output
module fcrc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  fcrc_pkg::fcrc_item_t  pop_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output fcrc_pkg::fcrc_result_t out_result
);

  logic [7:0] crc;
  logic [7:0] crc_next;
  logic [7:0] seq;
  logic [7:0] seq_next;
  logic [7:0] crc_in;
  logic       produce;
  logic       take;
  logic       kind_next;
  fcrc_pkg::fcrc_result_t result_next;

  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;
  assign crc_in    = (pop_item.cls == fcrc_pkg::CLS_SEQ) ? 8'd0 : crc;

  always_comb begin
    crc_next    = fcrc_pkg::crc8_update(crc_in, pop_item.data);
    seq_next    = seq;
    produce     = 1'b0;
    kind_next   = fcrc_pkg::RESULT_PAYLOAD;
    result_next = '0;
    unique case (pop_item.cls) inside
      fcrc_pkg::CLS_REG, fcrc_pkg::CLS_DATA: begin
        produce                  = 1'b1;
        result_next.payload_byte = pop_item.data;
        result_next.is_register  = (pop_item.cls == fcrc_pkg::CLS_REG);
      end
      fcrc_pkg::CLS_CRC: begin
        produce                  = 1'b1;
        kind_next                = fcrc_pkg::RESULT_STATUS;
        crc_next                 = 8'd0;
        result_next.crc_ok       = (pop_item.data == crc);
        result_next.expected_crc = crc;
      end
      fcrc_pkg::CLS_LEN: begin
      end
      default: begin
        seq_next = pop_item.data;
      end
    endcase
    result_next.frame_seq = seq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= 8'd0;
      seq       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        crc <= crc_next;
        seq <= seq_next;
      end
      if (take && produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      out_kind   <= kind_next;
      out_result <= result_next;
    end
  end

endmodule
